@@ hw/rtl/imu_sample_frame_packer_assert.svh @@
// ----------------------------------------------------------------------------
// imu sample frame packer assertion macros
// concurrent checks, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef IMU_SAMPLE_FRAME_PACKER_ASSERT_SVH
`define IMU_SAMPLE_FRAME_PACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define ISFP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("isfp assertion failed");
`define ISFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isfp assertion failed");
`else
`define ISFP_ASSERT(lbl, clk, rst_n, prop)
`define ISFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/isfp_pkg.sv @@
// ----------------------------------------------------------------------------
// isfp_pkg
// types, frame constants and crc-8 lookup tables for the frame packer
// ----------------------------------------------------------------------------
`default_nettype none

package isfp_pkg;

    localparam int FRAME_WORDS = 18;
    localparam int WORD_IDX_W  = $clog2(FRAME_WORDS);
    localparam logic [WORD_IDX_W-1:0] LAST_WORD_IDX = WORD_IDX_W'(FRAME_WORDS - 1);

    localparam logic [7:0]  SYNC_0   = 8'hA5;
    localparam logic [7:0]  SYNC_1   = 8'h5A;
    localparam logic [7:0]  SYNC_2   = 8'h00;
    localparam logic [7:0]  CMD_0    = 8'h10;
    localparam logic [7:0]  CMD_1    = 8'h40;
    localparam logic [7:0]  TAIL_CR  = 8'h0D;
    localparam logic [7:0]  TAIL_LF  = 8'h0A;
    localparam logic [7:0]  CRC_POLY = 8'h07;
    localparam logic [7:0]  CRC_TOP  = 8'h80;

    typedef struct packed {
        logic [63:0] timestamp_ms;
        logic [31:0] accel_x;
        logic [31:0] accel_y;
        logic [31:0] accel_z;
        logic [31:0] rate_x;
        logic [31:0] rate_y;
        logic [31:0] rate_z;
    } t_in_item;

    typedef struct packed {
        logic [31:0] frame_word;
        logic        last_word;
    } t_out_item;

    typedef struct packed {
        logic [7:0] frame_count;
        t_in_item   sample;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef logic [255:0][7:0] t_crc_tab;

    // table of crc state after 8*nbytes shift steps from each start value
    function automatic t_crc_tab build_crc_tab(input int nbytes);
        t_crc_tab   tab;
        logic [7:0] acc;
        for (int v = 0; v < 256; v++) begin
            acc = 8'(v);
            for (int s = 0; s < 8 * nbytes; s++) begin
                if ((acc & CRC_TOP) != 8'h00) begin
                    acc = (acc << 1) ^ CRC_POLY;
                end else begin
                    acc = acc << 1;
                end
            end
            tab[v] = acc;
        end
        return tab;
    endfunction

    localparam t_crc_tab CRC_TAB_1 = build_crc_tab(1);
    localparam t_crc_tab CRC_TAB_2 = build_crc_tab(2);
    localparam t_crc_tab CRC_TAB_3 = build_crc_tab(3);
    localparam t_crc_tab CRC_TAB_4 = build_crc_tab(4);

endpackage

`default_nettype wire

@@ hw/rtl/imu_sample_frame_packer.sv @@
// ----------------------------------------------------------------------------
// imu_sample_frame_packer
// packs a six-axis imu sample into a 72-byte crc-8 frame sent as 18 words
// ----------------------------------------------------------------------------
// input channel: one beat is a timestamp plus three accel and three rate words
// output channel: 18 beats per sample, 32-bit little-endian frame words,
//   last_word high on the eighteenth beat
// each sample is stamped with an 8-bit frame counter, incremented before use
// a sample beat is written into the fifo, then its first word into the output register
// output: one beat per cycle while the receiver is ready and a sample is queued;
//   crc-8 is folded four bytes per word beat
// a fifo of QUEUE_DEPTH samples, the streaming one included, takes new samples while not full
// reset: frame counter cleared, fifo and output register emptied
// receiver stall: the output word holds, serialization pauses, and input
//   ready drops once the fifo is full
// ----------------------------------------------------------------------------
`default_nettype none

module imu_sample_frame_packer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  isfp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output isfp_pkg::t_out_item o_out_data
);

    isfp_pkg::t_q_status w_status;
    isfp_pkg::t_entry    w_entry;
    isfp_pkg::t_entry    w_head;
    logic                w_push;
    logic                w_pop;

    isfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_status   (w_status),
        .o_push     (w_push),
        .o_entry    (w_entry)
    );

    isfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    isfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_status    (w_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ hw/rtl/isfp_front.sv @@
// ----------------------------------------------------------------------------
// isfp_front
// accepts samples, stamps each with the incremented frame counter
// ----------------------------------------------------------------------------
`default_nettype none

module isfp_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  isfp_pkg::t_in_item  i_in_data,
    input  isfp_pkg::t_q_status i_status,
    output logic                o_push,
    output isfp_pkg::t_entry    o_entry
);

    logic [7:0] r_frame_count;
    logic [7:0] n_frame_count;

    assign o_in_ready            = !i_status.full;
    assign o_push                = i_in_valid && !i_status.full;
    assign n_frame_count         = r_frame_count + 8'd1;
    assign o_entry.frame_count   = n_frame_count;
    assign o_entry.sample        = i_in_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= 8'd0;
        end else if (o_push) begin
            r_frame_count <= n_frame_count;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/isfp_queue.sv @@
// ----------------------------------------------------------------------------
// isfp_queue
// short fifo of stamped samples between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module isfp_queue #(
    parameter int DEPTH = 2
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  isfp_pkg::t_entry    i_entry,
    input  wire                 i_pop,
    output isfp_pkg::t_entry    o_head,
    output isfp_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    isfp_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/isfp_back.sv @@
// ----------------------------------------------------------------------------
// isfp_back
// serializes the head sample into 18 frame words, folding crc-8 per word
// ----------------------------------------------------------------------------
`default_nettype none

`include "imu_sample_frame_packer_assert.svh"

module isfp_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  isfp_pkg::t_entry    i_head,
    input  isfp_pkg::t_q_status i_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output isfp_pkg::t_out_item o_out_data
);

    logic [isfp_pkg::WORD_IDX_W-1:0] r_word_idx;
    logic [isfp_pkg::WORD_IDX_W-1:0] n_word_idx;
    logic [7:0]                      r_crc;
    logic [7:0]                      n_crc;
    logic                            r_out_valid;
    logic                            n_out_valid;
    isfp_pkg::t_out_item             r_out_data;
    isfp_pkg::t_out_item             n_out_data;
    logic                            w_load;
    logic                            w_is_last;
    logic [7:0]                      w_crc_base;
    logic [7:0]                      w_crc_byte;
    logic [31:0]                     w_word;

    function automatic logic [7:0] crc_fold(input logic [7:0] c, input logic [31:0] w);
        return isfp_pkg::CRC_TAB_4[c ^ w[7:0]] ^ isfp_pkg::CRC_TAB_3[w[15:8]]
             ^ isfp_pkg::CRC_TAB_2[w[23:16]] ^ isfp_pkg::CRC_TAB_1[w[31:24]];
    endfunction

    function automatic logic [31:0] build_word(
        input isfp_pkg::t_entry                e,
        input logic [isfp_pkg::WORD_IDX_W-1:0] idx,
        input logic [7:0]                      crc
    );
        logic [31:0] w;
        case (idx)
            5'd0: w = {isfp_pkg::CMD_0, isfp_pkg::SYNC_2, isfp_pkg::SYNC_1,
                       isfp_pkg::SYNC_0};
            5'd1: w = {e.sample.timestamp_ms[15:0], e.frame_count, isfp_pkg::CMD_1};
            5'd2: w = e.sample.timestamp_ms[47:16];
            5'd3: w = {e.sample.accel_x[15:0], e.sample.timestamp_ms[63:48]};
            5'd4: w = {e.sample.accel_y[15:0], e.sample.accel_x[31:16]};
            5'd5: w = {e.sample.accel_z[15:0], e.sample.accel_y[31:16]};
            5'd6: w = {e.sample.rate_x[15:0], e.sample.accel_z[31:16]};
            5'd7: w = {e.sample.rate_y[15:0], e.sample.rate_x[31:16]};
            5'd8: w = {e.sample.rate_z[15:0], e.sample.rate_y[31:16]};
            5'd9: w = {16'h0000, e.sample.rate_z[31:16]};
            isfp_pkg::LAST_WORD_IDX: w = {isfp_pkg::TAIL_LF, isfp_pkg::TAIL_CR, crc, 8'h00};
            default: w = 32'h0000_0000;
        endcase
        return w;
    endfunction

    // last word carries byte 68 (zero) before the crc, hence one extra byte step
    always_comb begin
        w_load     = !i_status.empty && (!r_out_valid || i_out_ready);
        w_is_last  = (r_word_idx == isfp_pkg::LAST_WORD_IDX);
        w_crc_base = (r_word_idx == '0) ? 8'h00 : r_crc;
        w_crc_byte = isfp_pkg::CRC_TAB_1[r_crc];
        w_word     = build_word(i_head, r_word_idx, w_crc_byte);
        n_crc      = crc_fold(w_crc_base, w_word);
        n_word_idx = w_is_last ? '0 : r_word_idx + 1'b1;
        n_out_data.frame_word = w_word;
        n_out_data.last_word  = w_is_last;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_pop       = w_load && w_is_last;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_load) begin
                r_word_idx <= n_word_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_crc      <= n_crc;
            r_out_data <= n_out_data;
        end
    end

    `ISFP_ASSERT(a_idx_range, i_clk, i_rst_n, r_word_idx <= isfp_pkg::LAST_WORD_IDX)
    `ISFP_ASSERT(a_head_held, i_clk, i_rst_n, (r_word_idx != '0) |-> !i_status.empty)
    `ISFP_ASSERT_NEXT(a_last_wraps, i_clk, i_rst_n, w_load && w_is_last, r_word_idx == '0 && r_out_valid && r_out_data.last_word)
    `ISFP_ASSERT(a_tail_bytes, i_clk, i_rst_n, (r_out_valid && r_out_data.last_word) |-> r_out_data.frame_word[31:16] == {isfp_pkg::TAIL_LF, isfp_pkg::TAIL_CR})

endmodule

`default_nettype wire
